### rtl/ntc_pkg.sv
// Shared constants for the numeric text classifier: character codes and
// result class codes. No dependencies.
package ntc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_EXP_L = 8'h65;
    localparam logic [CHAR_W-1:0] CHAR_EXP_U = 8'h45;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE = 2'd0,
        CLASS_INT  = 2'd1,
        CLASS_REAL = 2'd2
    } number_class_t;

endpackage

### rtl/numeric_text_classifier.sv
// Numeric text classifier top level: character state machine between an
// input register and a result register. Depends on ntc_pkg.
//
// Takes one character of a text field per item and, on the item with
// s_tlast high, returns one item whose m_tdata[1:0] is 0 (not a number),
// 1 (integer) or 2 (real: has a dot or an exponent). Leading and trailing
// spaces are ignored; an item with s_tuser low carries no character. The
// block accepts one item per cycle while no last item is held: each item passes
// through the input register, where the phase update is a single state machine step, and a
// result then waits in the output register while further items stream in.
// A last item stalls only while the previous result is still untaken.
module numeric_text_classifier
    import ntc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] has_char
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] number_class, [7:2] zero
);

    typedef enum logic [3:0] {
        PH_LEAD     = 4'd0,
        PH_SIGN     = 4'd1,
        PH_INT      = 4'd2,
        PH_DOT_BARE = 4'd3,
        PH_FRAC     = 4'd4,
        PH_EXP      = 4'd5,
        PH_EXP_SIGN = 4'd6,
        PH_EXP_DIG  = 4'd7,
        PH_BAD      = 4'd8
    } phase_t;

    // input register
    logic                in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_has_reg;
    logic                in_last_reg;

    // parse state
    phase_t              phase_reg, phase_next;
    logic                trail_reg, trail_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    number_class_t       out_class_reg, out_class_next;

    logic                advance;
    logic                is_dig, is_sgn, is_exp, is_space;
    phase_t              step_phase;
    logic                step_trail;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign is_dig   = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);
    assign is_sgn   = (in_char_reg == CHAR_PLUS) || (in_char_reg == CHAR_MINUS);
    assign is_exp   = (in_char_reg == CHAR_EXP_L) || (in_char_reg == CHAR_EXP_U);
    assign is_space = (in_char_reg == CHAR_SPACE);

    // one character step
    always_comb begin
        step_phase = phase_reg;
        step_trail = trail_reg;
        if (in_has_reg) begin
            if (is_space) begin
                if (phase_reg != PH_LEAD) step_trail = 1'b1;
            end else if (trail_reg) begin
                // non-space after the trailing run
                step_phase = PH_BAD;
            end else begin
                unique case (phase_reg)
                    PH_LEAD: begin
                        if (is_sgn) step_phase = PH_SIGN;
                        else if (is_dig) step_phase = PH_INT;
                        else if (in_char_reg == CHAR_DOT) step_phase = PH_DOT_BARE;
                        else step_phase = PH_BAD;
                    end
                    PH_SIGN: begin
                        if (is_dig) step_phase = PH_INT;
                        else if (in_char_reg == CHAR_DOT) step_phase = PH_DOT_BARE;
                        else step_phase = PH_BAD;
                    end
                    PH_INT: begin
                        if (is_dig) step_phase = PH_INT;
                        else if (in_char_reg == CHAR_DOT) step_phase = PH_FRAC;
                        else if (is_exp) step_phase = PH_EXP;
                        else step_phase = PH_BAD;
                    end
                    PH_DOT_BARE: begin
                        step_phase = is_dig ? PH_FRAC : PH_BAD;
                    end
                    PH_FRAC: begin
                        if (is_dig) step_phase = PH_FRAC;
                        else if (is_exp) step_phase = PH_EXP;
                        else step_phase = PH_BAD;
                    end
                    PH_EXP: begin
                        if (is_sgn) step_phase = PH_EXP_SIGN;
                        else if (is_dig) step_phase = PH_EXP_DIG;
                        else step_phase = PH_BAD;
                    end
                    PH_EXP_SIGN, PH_EXP_DIG: begin
                        step_phase = is_dig ? PH_EXP_DIG : PH_BAD;
                    end
                    default: begin
                        step_phase = PH_BAD;
                    end
                endcase
            end
        end
    end

    always_comb begin
        in_valid_next  = (in_valid_reg && !advance) || (s_tvalid && s_tready);
        phase_next     = phase_reg;
        trail_next     = trail_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_class_next = out_class_reg;
        if (advance) begin
            if (in_last_reg) begin
                phase_next     = PH_LEAD;
                trail_next     = 1'b0;
                out_valid_next = 1'b1;
                case (step_phase)
                    PH_INT:              out_class_next = CLASS_INT;
                    PH_FRAC, PH_EXP_DIG: out_class_next = CLASS_REAL;
                    default:             out_class_next = CLASS_NONE;
                endcase
            end else begin
                phase_next = step_phase;
                trail_next = step_trail;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_LEAD;
            trail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            trail_reg     <= trail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
        out_class_reg <= out_class_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - CLASS_W){1'b0}}, out_class_reg};

endmodule

### tb/tb_top.sv
// Self-checking testbench for numeric_text_classifier: streams text fields one character
// per item, predicts the number class of every field and checks each result in order.
// Depends on ntc_pkg and the numeric_text_classifier RTL.
module tb_top;
    import ntc_pkg::*;

    localparam int ITEM_TARGET   = 1800;
    localparam int QUIET_FROM    = 1500;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_PRINTED   = 50;

    typedef enum logic [3:0] {
        P_LEAD,
        P_SIGNED,
        P_WHOLE,
        P_BARE_DOT,
        P_FRACTION,
        P_EXP_MARK,
        P_EXP_SIGN,
        P_EXP_DIGITS,
        P_INVALID
    } parse_phase_t;

    // Predicts the class of each field and holds the classes still owed by the block.
    class number_scoreboard;
        parse_phase_t  phase;
        bit            trailing;
        number_class_t owed_q[$];

        function new();
            restart();
        endfunction

        function void restart();
            phase    = P_LEAD;
            trailing = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function bit is_sign(logic [7:0] c);
            return c == CHAR_PLUS || c == CHAR_MINUS;
        endfunction

        function bit is_mark(logic [7:0] c);
            return c == CHAR_EXP_L || c == CHAR_EXP_U;
        endfunction

        function parse_phase_t advance(parse_phase_t ph, logic [7:0] c);
            case (ph)
                P_LEAD: begin
                    if (is_sign(c)) return P_SIGNED;
                    if (is_digit(c)) return P_WHOLE;
                    if (c == CHAR_DOT) return P_BARE_DOT;
                end
                P_SIGNED: begin
                    if (is_digit(c)) return P_WHOLE;
                    if (c == CHAR_DOT) return P_BARE_DOT;
                end
                P_WHOLE: begin
                    if (is_digit(c)) return P_WHOLE;
                    if (c == CHAR_DOT) return P_FRACTION;
                    if (is_mark(c)) return P_EXP_MARK;
                end
                P_BARE_DOT: begin
                    if (is_digit(c)) return P_FRACTION;
                end
                P_FRACTION: begin
                    if (is_digit(c)) return P_FRACTION;
                    if (is_mark(c)) return P_EXP_MARK;
                end
                P_EXP_MARK: begin
                    if (is_sign(c)) return P_EXP_SIGN;
                    if (is_digit(c)) return P_EXP_DIGITS;
                end
                P_EXP_SIGN, P_EXP_DIGITS: begin
                    if (is_digit(c)) return P_EXP_DIGITS;
                end
                default: ;
            endcase
            return P_INVALID;
        endfunction

        function void note_item(logic [7:0] c, bit has, bit last);
            if (has) begin
                if (c == CHAR_SPACE) begin
                    if (phase != P_LEAD) trailing = 1'b1;
                end else if (trailing) begin
                    phase = P_INVALID;
                end else begin
                    phase = advance(phase, c);
                end
            end
            if (last) begin
                if (phase == P_WHOLE)
                    owed_q.push_back(CLASS_INT);
                else if (phase == P_FRACTION || phase == P_EXP_DIGITS)
                    owed_q.push_back(CLASS_REAL);
                else
                    owed_q.push_back(CLASS_NONE);
                restart();
            end
        endfunction

        // Empty string when the result matches the oldest owed class.
        function string check_result(logic [7:0] data);
            number_class_t want;
            if (owed_q.size() == 0)
                return $sformatf("result 0x%02h with no field pending", data);
            want = owed_q.pop_front();
            if (data !== {6'b0, want})
                return $sformatf("class got 0x%02h want %0d", data, want);
            return "";
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    number_scoreboard sb;
    logic [7:0]       field_buf[$];
    int               mismatches;
    int               items_sent;
    int               idle_pct;
    bit               quiet;
    bit               sprinkle;
    int               stall_count = 0;

    numeric_text_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    task report(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task send_item(input logic [7:0] c, input bit has, input bit last);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(c, has, last);
        items_sent++;
    endtask

    // Sends field_buf as one field; an empty buffer or tail_blank ends it with a no-char item.
    task send_field(input bit tail_blank);
        int n;
        n = field_buf.size();
        for (int i = 0; i < n; i++) begin
            if (sprinkle && $urandom_range(0, 7) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(field_buf[i], 1'b1, (i == n - 1) && !tail_blank);
        end
        if (n == 0 || tail_blank)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task load_text(input string s);
        field_buf.delete();
        for (int i = 0; i < s.len(); i++)
            field_buf.push_back(s[i]);
    endtask

    function logic [7:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return CHAR_SPACE;
            2: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            3: return CHAR_DOT;
            4: return $urandom_range(0, 1) ? CHAR_EXP_L : CHAR_EXP_U;
            default: return CHAR_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    task push_digits(input int n);
        repeat (n) field_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task push_spaces();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) field_buf.push_back(CHAR_SPACE);
    endtask

    // Mostly well-formed literal; some parts may come out empty, which can break it.
    task build_number();
        field_buf.delete();
        push_spaces();
        if ($urandom_range(0, 2) == 0)
            field_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        push_digits($urandom_range(0, 4));
        if ($urandom_range(0, 1)) begin
            field_buf.push_back(CHAR_DOT);
            push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 9) < 3) begin
            field_buf.push_back($urandom_range(0, 1) ? CHAR_EXP_L : CHAR_EXP_U);
            if ($urandom_range(0, 2) == 0)
                field_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            push_digits($urandom_range(0, 3));
        end
        push_spaces();
    endtask

    task mutate();
        int idx;
        if (field_buf.size() == 0) return;
        idx = $urandom_range(0, field_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: field_buf[idx] = pick_char();
            1: field_buf.insert(idx, pick_char());
            default: field_buf.insert(idx, CHAR_SPACE);
        endcase
    endtask

    // Sink side: bursts of readiness and stalls, always ready once the run goes quiet.
    initial begin
        @(posedge aclk);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_tvalid && m_tready) begin
            msg = sb.check_result(m_tdata);
            if (msg != "") report(msg);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        sb          = new();
        mismatches  = 0;
        items_sent  = 0;
        idle_pct    = 15;
        quiet       = 1'b0;
        sprinkle    = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed fields
        load_text("0");    send_field(1'b0);
        load_text("+");    send_field(1'b0);
        load_text(".");    send_field(1'b0);
        load_text("7.");   send_field(1'b0);
        load_text("-.5");  send_field(1'b0);
        load_text("1E+9"); send_field(1'b0);
        load_text("3e");   send_field(1'b0);
        load_text(" 8 ");  send_field(1'b0);
        load_text("1 2");  send_field(1'b0);
        field_buf.delete(); send_field(1'b0);               // empty field
        field_buf.delete(); field_buf.push_back(8'h00); send_field(1'b0);
        field_buf.delete(); field_buf.push_back(8'hFF); send_field(1'b0);
        load_text("1");    send_field(1'b1);                // closed by a no-char item

        while (items_sent < ITEM_TARGET) begin
            quiet    = items_sent >= QUIET_FROM;
            sprinkle = $urandom_range(0, 9) == 0;
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 40;
                default: idle_pct = 10;
            endcase
            r = $urandom_range(0, 99);
            if (r < 65) begin
                build_number();
                if ($urandom_range(0, 4) == 0) mutate();
            end else if (r < 85) begin
                field_buf.delete();
                repeat ($urandom_range(1, 8)) field_buf.push_back(pick_char());
            end else if (r < 92) begin
                field_buf.delete();
            end else begin
                build_number();
                field_buf.insert($urandom_range(0, field_buf.size()), CHAR_SPACE);
            end
            send_field($urandom_range(0, 19) == 0);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
